// ----- hdl/c8rf_pkg.sv -----
package c8rf_pkg;

  localparam int unsigned STACK_DEPTH = 16;
  localparam int unsigned NUM_VREGS   = 16;
  localparam int unsigned VIDX_W      = $clog2(NUM_VREGS);
  localparam int unsigned STK_AW      = $clog2(STACK_DEPTH);
  localparam int unsigned SP_W        = $clog2(STACK_DEPTH + 1);
  localparam logic [VIDX_W-1:0] FLAG_REG = VIDX_W'(4'hF);

  typedef enum logic [3:0] {
    OP_MOVE   = 4'd0,
    OP_OR     = 4'd1,
    OP_AND    = 4'd2,
    OP_XOR    = 4'd3,
    OP_ADD    = 4'd4,
    OP_SUB    = 4'd5,
    OP_SHR    = 4'd6,
    OP_SUBN   = 4'd7,
    OP_SHL    = 4'd8,
    OP_LOAD   = 4'd9,
    OP_PUSH   = 4'd10,
    OP_POP    = 4'd11,
    OP_SETPC  = 4'd12,
    OP_PC2    = 4'd13,
    OP_PC1    = 4'd14,
    OP_CLRF   = 4'd15
  } op_t;

  // Outcome of one ALU step: result byte, flag bit and the two write enables.
  typedef struct packed {
    logic [7:0] res;
    logic       flag;
    logic       wr_dst;
    logic       wr_flag;
  } alu_res_t;

endpackage

// ----- hdl/c8rf_if.sv -----
interface c8rf_cmd_if;
  logic        valid;
  logic        ready;
  logic [3:0]  op;
  logic [3:0]  src_reg;
  logic [3:0]  dst_reg;
  logic [15:0] value;

  modport source (output valid, output op, output src_reg, output dst_reg, output value,
                  input ready);
  modport sink (input valid, input op, input src_reg, input dst_reg, input value,
                output ready);
endinterface

interface c8rf_rsp_if;
  logic        valid;
  logic        ready;
  logic [7:0]  dst_value;
  logic        flag_value;
  logic [15:0] pc_value;
  logic [15:0] popped_word;
  logic        stack_fault;

  modport source (output valid, output dst_value, output flag_value, output pc_value,
                  output popped_word, output stack_fault, input ready);
  modport sink (input valid, input dst_value, input flag_value, input pc_value,
                input popped_word, input stack_fault, output ready);
endinterface

// ----- hdl/c8rf_alu.sv -----
module c8rf_alu (
  input  logic [3:0]        op,
  input  logic [7:0]        x,
  input  logic [7:0]        y,
  input  logic [7:0]        imm,
  output c8rf_pkg::alu_res_t result
);

  logic [8:0] sum;
  logic [8:0] diff_yx;
  logic [8:0] diff_xy;

  // The ninth bit of each difference is the borrow.
  assign sum     = {1'b0, x} + {1'b0, y};
  assign diff_yx = {1'b0, y} - {1'b0, x};
  assign diff_xy = {1'b0, x} - {1'b0, y};

  always_comb begin
    result = '0;
    unique case (c8rf_pkg::op_t'(op))
      c8rf_pkg::OP_MOVE: begin
        result.res = x;
        result.wr_dst = 1'b1;
      end
      c8rf_pkg::OP_OR: begin
        result.res = x | y;
        result.wr_dst = 1'b1;
      end
      c8rf_pkg::OP_AND: begin
        result.res = x & y;
        result.wr_dst = 1'b1;
      end
      c8rf_pkg::OP_XOR: begin
        result.res = x ^ y;
        result.wr_dst = 1'b1;
      end
      c8rf_pkg::OP_ADD: begin
        result.res = sum[7:0];
        result.flag = sum[8];
        result.wr_dst = 1'b1;
        result.wr_flag = 1'b1;
      end
      c8rf_pkg::OP_SUB: begin
        result.res = diff_yx[7:0];
        result.flag = ~diff_yx[8];
        result.wr_dst = 1'b1;
        result.wr_flag = 1'b1;
      end
      c8rf_pkg::OP_SHR: begin
        result.res = {1'b0, x[7:1]};
        result.flag = x[0];
        result.wr_dst = 1'b1;
        result.wr_flag = 1'b1;
      end
      c8rf_pkg::OP_SUBN: begin
        result.res = diff_xy[7:0];
        result.flag = ~diff_xy[8];
        result.wr_dst = 1'b1;
        result.wr_flag = 1'b1;
      end
      c8rf_pkg::OP_SHL: begin
        result.res = {x[6:0], 1'b0};
        result.flag = x[7];
        result.wr_dst = 1'b1;
        result.wr_flag = 1'b1;
      end
      c8rf_pkg::OP_LOAD: begin
        result.res = imm;
        result.wr_dst = 1'b1;
      end
      c8rf_pkg::OP_CLRF: begin
        result.flag = 1'b0;
        result.wr_flag = 1'b1;
      end
      default: begin
        result = '0;
      end
    endcase
  end

endmodule

// ----- hdl/chip8_register_file_alu.sv -----
// Register file and ALU of a CHIP-8 style machine: sixteen 8-bit V registers
// (VF is the flag), a 16-bit program counter and a return stack.
// Commands arrive on the cmd channel and one response per command leaves on
// the rsp channel; a transaction completes when valid and ready are both high.
// A command is captured in an input register, together with the V register
// operands and the stack top, which are read in the same cycle with bypass of
// the write made by the command ahead of it. Once the response register is free
// or being emptied, the ALU runs, the state is written and the response
// register is loaded; rsp.valid rises when that register is loaded.
// Throughput is one command per cycle while the receiver keeps rsp.ready high;
// the limit is the single ALU step plus the state update between the input
// register and the response register.
// A stalled receiver holds the response register; the input register can
// still take one more command, after which cmd.ready drops until rsp moves.
// Synchronous reset clears the V registers, the stack pointer, the program
// counter and all valid flags. Stack entries are not cleared; only entries
// written by a push are ever popped.
module chip8_register_file_alu (
  input logic           clk,
  input logic           rst,
  c8rf_cmd_if.sink      cmd,
  c8rf_rsp_if.source    rsp
);

  // Input register stage.
  logic                          s1_valid;
  logic [3:0]                    s1_op;
  logic [c8rf_pkg::VIDX_W-1:0]   s1_dst;
  logic [15:0]                   s1_value;
  logic [7:0]                    s1_x;
  logic [7:0]                    s1_y;
  logic [15:0]                   s1_top;

  // Architectural state.
  logic [7:0]                    vregs [c8rf_pkg::NUM_VREGS];
  logic [15:0]                   stack_mem [c8rf_pkg::STACK_DEPTH];
  logic [c8rf_pkg::SP_W-1:0]     sp;
  logic [c8rf_pkg::SP_W-1:0]     sp_next;
  logic [15:0]                   pc;
  logic [15:0]                   pc_next;

  logic                          fire;
  logic                          accept;
  c8rf_pkg::alu_res_t            alu;
  logic [7:0]                    flag_byte;
  logic [7:0]                    vf_next;
  logic [7:0]                    dst_out;
  logic                          is_push;
  logic                          is_pop;
  logic                          push_ok;
  logic                          pop_ok;
  logic [c8rf_pkg::SP_W-1:0]     sp_after;
  logic [c8rf_pkg::SP_W-1:0]     rd_ptr;
  logic [c8rf_pkg::VIDX_W-1:0]   src_idx;
  logic [c8rf_pkg::VIDX_W-1:0]   dst_idx;

  // The command in the input register completes when the response register
  // is free or is being emptied in this cycle.
  assign fire      = s1_valid && (!rsp.valid || rsp.ready);
  assign cmd.ready = !s1_valid || fire;
  assign accept    = cmd.valid && cmd.ready;

  assign src_idx = c8rf_pkg::VIDX_W'(cmd.src_reg);
  assign dst_idx = c8rf_pkg::VIDX_W'(cmd.dst_reg);

  c8rf_alu u_alu (
    .op     (s1_op),
    .x      (s1_x),
    .y      (s1_y),
    .imm    (s1_value[7:0]),
    .result (alu)
  );

  assign flag_byte = {7'd0, alu.flag};

  // The flag is written after the result, so it wins when the destination is VF.
  always_comb begin
    if (alu.wr_flag) begin
      vf_next = flag_byte;
    end else if (alu.wr_dst && s1_dst == c8rf_pkg::FLAG_REG) begin
      vf_next = alu.res;
    end else begin
      vf_next = vregs[c8rf_pkg::FLAG_REG];
    end
    if (alu.wr_flag && s1_dst == c8rf_pkg::FLAG_REG) begin
      dst_out = flag_byte;
    end else if (alu.wr_dst) begin
      dst_out = alu.res;
    end else begin
      dst_out = s1_y;
    end
  end

  // Stack pointer and program counter updates.
  assign is_push = (c8rf_pkg::op_t'(s1_op) == c8rf_pkg::OP_PUSH);
  assign is_pop  = (c8rf_pkg::op_t'(s1_op) == c8rf_pkg::OP_POP);
  assign push_ok = is_push && (sp < c8rf_pkg::SP_W'(c8rf_pkg::STACK_DEPTH));
  assign pop_ok  = is_pop && (sp != '0);

  always_comb begin
    if (push_ok) begin
      sp_next = sp + c8rf_pkg::SP_W'(1);
    end else if (pop_ok) begin
      sp_next = sp - c8rf_pkg::SP_W'(1);
    end else begin
      sp_next = sp;
    end
    unique case (c8rf_pkg::op_t'(s1_op))
      c8rf_pkg::OP_SETPC: pc_next = s1_value;
      c8rf_pkg::OP_PC2:   pc_next = pc + 16'd2;
      c8rf_pkg::OP_PC1:   pc_next = pc + 16'd1;
      default:            pc_next = pc;
    endcase
  end

  // Stack pointer seen by a command captured in this cycle.
  assign sp_after = fire ? sp_next : sp;
  assign rd_ptr   = sp_after - c8rf_pkg::SP_W'(1);

  // V registers: reset to zero, written by the command in the ALU stage.
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < int'(c8rf_pkg::NUM_VREGS); i++) begin
        vregs[i] <= 8'd0;
      end
    end else if (fire) begin
      if (alu.wr_dst) begin
        vregs[s1_dst] <= alu.res;
      end
      if (alu.wr_flag) begin
        vregs[c8rf_pkg::FLAG_REG] <= flag_byte;
      end
    end
  end

  // Return stack storage; contents are undefined until pushed.
  always_ff @(posedge clk) begin
    if (fire && push_ok) begin
      stack_mem[sp[c8rf_pkg::STK_AW-1:0]] <= s1_value;
    end
  end

  // Input register with operand reads. The command ahead of this one writes
  // its state in the same cycle, so its writes are bypassed into the reads.
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (cmd.ready) begin
      s1_valid <= cmd.valid;
    end
    if (accept) begin
      s1_op    <= cmd.op;
      s1_dst   <= dst_idx;
      s1_value <= cmd.value;
      if (fire && alu.wr_flag && src_idx == c8rf_pkg::FLAG_REG) begin
        s1_x <= flag_byte;
      end else if (fire && alu.wr_dst && src_idx == s1_dst) begin
        s1_x <= alu.res;
      end else begin
        s1_x <= vregs[src_idx];
      end
      if (fire && alu.wr_flag && dst_idx == c8rf_pkg::FLAG_REG) begin
        s1_y <= flag_byte;
      end else if (fire && alu.wr_dst && dst_idx == s1_dst) begin
        s1_y <= alu.res;
      end else begin
        s1_y <= vregs[dst_idx];
      end
      // A push ahead of this command leaves its own word on top.
      if (fire && push_ok) begin
        s1_top <= s1_value;
      end else begin
        s1_top <= stack_mem[rd_ptr[c8rf_pkg::STK_AW-1:0]];
      end
    end
  end

  // Stack pointer, program counter and the response register.
  always_ff @(posedge clk) begin
    if (rst) begin
      sp        <= '0;
      pc        <= 16'd0;
      rsp.valid <= 1'b0;
    end else begin
      if (fire) begin
        sp        <= sp_next;
        pc        <= pc_next;
        rsp.valid <= 1'b1;
      end else if (rsp.ready) begin
        rsp.valid <= 1'b0;
      end
    end
    if (fire) begin
      rsp.dst_value   <= dst_out;
      rsp.flag_value  <= (vf_next != 8'd0);
      rsp.pc_value    <= pc_next;
      rsp.popped_word <= pop_ok ? s1_top : 16'd0;
      rsp.stack_fault <= (is_push && !push_ok) || (is_pop && !pop_ok);
    end
  end

endmodule

// ----- bench/chip8_register_file_alu_test.sv -----
`timescale 1ns / 1ps

// Self-checking bench for the CHIP-8 register file and ALU.
//
// Commands are queued up front: first a short hand-written table that walks
// the field extremes, every operation and the awkward corners (flag register
// as destination, NOT-borrow on equal operands, shift-out of the top bit,
// PC wrap, stack underflow), then about a thousand random commands grouped
// into segments. A command transaction happens at a rising edge with valid
// and ready both high. At that edge the bench runs the command on its own
// copy of the V registers, stack and PC and queues the outcome. Table rows
// whose outcome is obvious carry it typed in, and that typed outcome is
// queued instead. Each response transaction is checked field by field
// against the oldest queued outcome.
module chip8_register_file_alu_test;
  import c8rf_pkg::*;

  // One command plus, for table rows, the outcome that is typed in for it.
  typedef struct packed {
    logic [7:0]  dst_value;
    logic        flag_value;
    logic [15:0] pc_value;
    logic [15:0] popped_word;
    logic        stack_fault;
  } outcome_t;

  typedef struct packed {
    op_t         op;
    logic [3:0]  src;
    logic [3:0]  dst;
    logic [15:0] value;
    logic        fixed;
    outcome_t    want;
  } chip8_op_t;

  localparam int RANDOM_ITEMS = 1000;
  // The drain leaves room for a stray extra response to show up.
  localparam int DRAIN_CYCLES = 10;
  // Stalls from gap_len on either side are far shorter than IDLE_LIMIT, so
  // reaching it without any transaction can only mean the block is stuck.
  localparam int IDLE_LIMIT   = 1000;

  localparam outcome_t PREDICT = '0;

  // Opening table. Rows with fixed set carry their outcome; the rest are
  // checked against the running prediction.
  localparam chip8_op_t OPENING_OPS [27] = '{
    // After reset everything reads zero; the unused value field is ignored.
    '{OP_MOVE,  4'd1,  4'd0,  16'hFFFF, 1'b1, '{8'h00, 1'b0, 16'h0000, 16'h0000, 1'b0}},
    // Pop with nothing on the stack.
    '{OP_POP,   4'd0,  4'd0,  16'h0000, 1'b1, '{8'h00, 1'b0, 16'h0000, 16'h0000, 1'b1}},
    // Load takes only the low byte.
    '{OP_LOAD,  4'd0,  4'd1,  16'hFFFF, 1'b1, '{8'hFF, 1'b0, 16'h0000, 16'h0000, 1'b0}},
    '{OP_LOAD,  4'd0,  4'd2,  16'h0001, 1'b1, '{8'h01, 1'b0, 16'h0000, 16'h0000, 1'b0}},
    // 0xFF + 0x01 carries out.
    '{OP_ADD,   4'd2,  4'd1,  16'h0000, 1'b1, '{8'h00, 1'b1, 16'h0000, 16'h0000, 1'b0}},
    // 0x00 - 0x01 borrows, so the flag drops.
    '{OP_SUB,   4'd2,  4'd1,  16'h0000, 1'b1, '{8'hFF, 1'b0, 16'h0000, 16'h0000, 1'b0}},
    '{OP_SUBN,  4'd1,  4'd2,  16'h0000, 1'b0, PREDICT},
    '{OP_SHR,   4'd1,  4'd3,  16'h0000, 1'b0, PREDICT},
    // Shift into VF itself: the flag overwrites the shifted byte.
    '{OP_SHL,   4'd1,  4'd15, 16'h0000, 1'b0, PREDICT},
    '{OP_CLRF,  4'd0,  4'd15, 16'h0000, 1'b1, '{8'h00, 1'b0, 16'h0000, 16'h0000, 1'b0}},
    '{OP_OR,    4'd1,  4'd4,  16'h0000, 1'b0, PREDICT},
    '{OP_AND,   4'd2,  4'd4,  16'h0000, 1'b0, PREDICT},
    '{OP_XOR,   4'd1,  4'd1,  16'h0000, 1'b0, PREDICT},
    '{OP_LOAD,  4'd0,  4'd6,  16'h5A80, 1'b0, PREDICT},
    '{OP_SHL,   4'd6,  4'd7,  16'h0000, 1'b0, PREDICT},
    // Equal operands: no borrow, so the flag is set.
    '{OP_SUB,   4'd3,  4'd3,  16'h0000, 1'b0, PREDICT},
    '{OP_ADD,   4'd1,  4'd15, 16'h0000, 1'b0, PREDICT},
    '{OP_SETPC, 4'd0,  4'd0,  16'hFFFF, 1'b0, PREDICT},
    '{OP_PC1,   4'd0,  4'd0,  16'h0000, 1'b0, PREDICT},
    '{OP_PC2,   4'd0,  4'd0,  16'h0000, 1'b0, PREDICT},
    '{OP_SETPC, 4'd0,  4'd0,  16'hFFFE, 1'b0, PREDICT},
    '{OP_PC2,   4'd0,  4'd0,  16'h0000, 1'b0, PREDICT},
    '{OP_PUSH,  4'd0,  4'd0,  16'hFFFF, 1'b0, PREDICT},
    '{OP_PUSH,  4'd0,  4'd0,  16'h0000, 1'b0, PREDICT},
    '{OP_POP,   4'd0,  4'd0,  16'h0000, 1'b0, PREDICT},
    '{OP_POP,   4'd0,  4'd0,  16'h0000, 1'b0, PREDICT},
    '{OP_POP,   4'd0,  4'd0,  16'h0000, 1'b0, PREDICT}
  };

  logic clk;
  logic rst;

  c8rf_cmd_if cmd_ch ();
  c8rf_rsp_if rsp_ch ();

  chip8_register_file_alu DUT (
    .clk (clk),
    .rst (rst),
    .cmd (cmd_ch),
    .rsp (rsp_ch)
  );

  // Bench copy of the architectural state.
  logic [7:0]  vreg_copy [NUM_VREGS];
  logic [15:0] stack_copy [STACK_DEPTH];
  int          sp_copy;
  logic [15:0] pc_copy;

  chip8_op_t   op_program [$];   // commands still to be sent
  outcome_t    op_outcomes [$];  // outcomes of accepted commands, oldest first
  chip8_op_t   cur_op;           // command currently on the cmd channel

  int total_ops;
  int cmd_count;
  int rsp_count;
  int error_count;
  int send_hold;
  int recv_hold;
  bit send_calm;
  bit recv_calm;

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Runs one command on the bench copy of the state and returns what the
  // response should carry. Operands are read before any register is written,
  // and the flag is written after the destination, so a destination of VF
  // ends up holding the flag.
  task automatic execute_op(input chip8_op_t c, output outcome_t r);
    logic [7:0] x;
    logic [7:0] y;
    logic [8:0] sum;
    x = vreg_copy[c.src];
    y = vreg_copy[c.dst];
    r = '0;
    case (c.op)
      OP_MOVE: vreg_copy[c.dst] = x;
      OP_OR:   vreg_copy[c.dst] = x | y;
      OP_AND:  vreg_copy[c.dst] = x & y;
      OP_XOR:  vreg_copy[c.dst] = x ^ y;
      OP_ADD: begin
        sum = {1'b0, x} + {1'b0, y};
        vreg_copy[c.dst] = sum[7:0];
        vreg_copy[FLAG_REG] = {7'd0, sum[8]};
      end
      OP_SUB: begin
        vreg_copy[c.dst] = y - x;
        vreg_copy[FLAG_REG] = {7'd0, y >= x};
      end
      OP_SHR: begin
        vreg_copy[c.dst] = x >> 1;
        vreg_copy[FLAG_REG] = {7'd0, x[0]};
      end
      OP_SUBN: begin
        vreg_copy[c.dst] = x - y;
        vreg_copy[FLAG_REG] = {7'd0, x >= y};
      end
      OP_SHL: begin
        vreg_copy[c.dst] = x << 1;
        vreg_copy[FLAG_REG] = {7'd0, x[7]};
      end
      OP_LOAD: vreg_copy[c.dst] = c.value[7:0];
      OP_PUSH: begin
        if (sp_copy >= STACK_DEPTH) begin
          r.stack_fault = 1'b1;
        end else begin
          stack_copy[sp_copy] = c.value;
          sp_copy++;
        end
      end
      OP_POP: begin
        // Only entries written by a push are ever read back here.
        if (sp_copy == 0) begin
          r.stack_fault = 1'b1;
        end else begin
          sp_copy--;
          r.popped_word = stack_copy[sp_copy];
        end
      end
      OP_SETPC: pc_copy = c.value;
      OP_PC2:   pc_copy = pc_copy + 16'd2;
      OP_PC1:   pc_copy = pc_copy + 16'd1;
      default:  vreg_copy[FLAG_REG] = 8'd0;
    endcase
    r.dst_value  = vreg_copy[c.dst];
    r.flag_value = (vreg_copy[FLAG_REG] != 8'd0);
    r.pc_value   = pc_copy;
  endtask

  task automatic report_mismatch(input string what, input logic [15:0] got,
                                 input logic [15:0] want);
    error_count++;
    $display("response %0d: %s is %h, expected %h", rsp_count, what, got, want);
  endtask

  task automatic add_op(input op_t op, input logic [3:0] src, input logic [3:0] dst,
                        input logic [15:0] value);
    chip8_op_t c;
    c.op    = op;
    c.src   = src;
    c.dst   = dst;
    c.value = value;
    c.fixed = 1'b0;
    c.want  = '0;
    op_program.push_back(c);
  endtask

  // Register indexes lean toward VF, where most of the interesting
  // interactions happen.
  function automatic logic [3:0] pick_reg();
    if ($urandom_range(0, 3) == 0) return FLAG_REG;
    return 4'($urandom_range(0, 15));
  endfunction

  function automatic logic [7:0] pick_byte();
    case ($urandom_range(0, 7))
      0: return 8'h00;
      1: return 8'hFF;
      2: return 8'h80;
      3: return 8'h7F;
      4: return 8'h01;
      default: return 8'($urandom());
    endcase
  endfunction

  function automatic logic [15:0] pick_word();
    case ($urandom_range(0, 5))
      0: return 16'h0000;
      1: return 16'hFFFF;
      2: return 16'hFFFE;
      default: return 16'($urandom());
    endcase
  endfunction

  // Idle length between transactions: mostly none or short, a few long.
  // In a calm stretch there is no idling at all.
  function automatic int gap_len(input bit calm);
    int roll;
    roll = $urandom_range(0, 99);
    if (calm || roll < 55) return 0;
    if (roll < 88) return $urandom_range(1, 3);
    if (roll < 98) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // Command side. The bench predicts at the edge where the command
  // transaction happens, then either holds valid low for a gap or puts up
  // the next command. Valid gets at most one assignment per edge.
  always @(posedge clk) begin
    outcome_t predicted;
    if (rst) begin
      cmd_ch.valid <= 1'b0;
    end else begin
      if (cmd_ch.valid && cmd_ch.ready) begin
        cmd_count++;
        execute_op(cur_op, predicted);
        if (cur_op.fixed) begin
          op_outcomes.push_back(cur_op.want);
        end else begin
          op_outcomes.push_back(predicted);
        end
        send_hold = gap_len(send_calm);
        if ($urandom_range(0, 63) == 0) send_calm = !send_calm;
      end
      if (!cmd_ch.valid || cmd_ch.ready) begin
        if (send_hold > 0) begin
          cmd_ch.valid <= 1'b0;
          send_hold--;
        end else if (op_program.size() != 0) begin
          cur_op = op_program.pop_front();
          cmd_ch.op      <= cur_op.op;
          cmd_ch.src_reg <= cur_op.src;
          cmd_ch.dst_reg <= cur_op.dst;
          cmd_ch.value   <= cur_op.value;
          cmd_ch.valid   <= 1'b1;
        end else begin
          cmd_ch.valid <= 1'b0;
        end
      end
    end
  end

  // Response side: every response transaction is checked against the oldest
  // queued outcome, after which ready may drop for a random gap.
  always @(posedge clk) begin
    outcome_t want;
    if (rst) begin
      rsp_ch.ready <= 1'b0;
    end else begin
      if (rsp_ch.valid && rsp_ch.ready) begin
        rsp_count++;
        if (op_outcomes.size() == 0) begin
          report_mismatch("unexpected response, dst_value", {8'd0, rsp_ch.dst_value}, 16'd0);
        end else begin
          want = op_outcomes.pop_front();
          if (rsp_ch.dst_value !== want.dst_value)
            report_mismatch("dst_value", {8'd0, rsp_ch.dst_value}, {8'd0, want.dst_value});
          if (rsp_ch.flag_value !== want.flag_value)
            report_mismatch("flag_value", {15'd0, rsp_ch.flag_value},
                            {15'd0, want.flag_value});
          if (rsp_ch.pc_value !== want.pc_value)
            report_mismatch("pc_value", rsp_ch.pc_value, want.pc_value);
          if (rsp_ch.popped_word !== want.popped_word)
            report_mismatch("popped_word", rsp_ch.popped_word, want.popped_word);
          if (rsp_ch.stack_fault !== want.stack_fault)
            report_mismatch("stack_fault", {15'd0, rsp_ch.stack_fault},
                            {15'd0, want.stack_fault});
        end
        recv_hold = gap_len(recv_calm);
        if ($urandom_range(0, 63) == 0) recv_calm = !recv_calm;
      end
      if (recv_hold > 0) begin
        rsp_ch.ready <= 1'b0;
        recv_hold--;
      end else begin
        rsp_ch.ready <= 1'b1;
      end
    end
  end

  // Counters are sampled on the falling edge, away from the edge where the
  // two channel processes update them.
  initial begin
    int idle;
    int last_seen;
    idle = 0;
    last_seen = 0;
    forever begin
      @(negedge clk);
      if (cmd_count + rsp_count != last_seen) begin
        last_seen = cmd_count + rsp_count;
        idle = 0;
      end else begin
        idle++;
      end
      if (idle >= IDLE_LIMIT) begin
        $display("no transaction for %0d cycles", IDLE_LIMIT);
        $display("simulation failed");
        $finish;
      end
    end
  end

  initial begin
    int k;
    int depth;
    int extra;
    int count;
    rst = 1'b1;
    cmd_ch.valid   = 1'b0;
    cmd_ch.op      = OP_MOVE;
    cmd_ch.src_reg = 4'd0;
    cmd_ch.dst_reg = 4'd0;
    cmd_ch.value   = 16'd0;
    rsp_ch.ready   = 1'b0;
    cmd_count = 0;
    rsp_count = 0;
    error_count = 0;
    send_hold = 0;
    recv_hold = 0;
    send_calm = 1'b0;
    recv_calm = 1'b0;
    for (k = 0; k < NUM_VREGS; k++) vreg_copy[k] = 8'd0;
    for (k = 0; k < STACK_DEPTH; k++) stack_copy[k] = 16'd0;
    sp_copy = 0;
    pc_copy = 16'd0;

    for (k = 0; k < $size(OPENING_OPS); k++) op_program.push_back(OPENING_OPS[k]);

    // Random part, built from segments: ALU bursts, push/pop sequences that
    // run past full and past empty now and then, PC runs around the wrap
    // point, and plain noise over every field.
    while (op_program.size() < $size(OPENING_OPS) + RANDOM_ITEMS) begin
      case ($urandom_range(0, 9))
        0, 1, 2, 3: begin
          count = $urandom_range(4, 16);
          for (k = 0; k < count; k++) begin
            if ($urandom_range(0, 3) == 0) begin
              add_op(OP_LOAD, pick_reg(), pick_reg(), {8'($urandom()), pick_byte()});
            end else if ($urandom_range(0, 7) == 0) begin
              add_op(OP_CLRF, pick_reg(), pick_reg(), 16'($urandom()));
            end else begin
              add_op(op_t'($urandom_range(0, 8)), pick_reg(), pick_reg(), 16'($urandom()));
            end
          end
        end
        4, 5: begin
          depth = $urandom_range(1, STACK_DEPTH + 3);
          for (k = 0; k < depth; k++) begin
            add_op(OP_PUSH, pick_reg(), pick_reg(), pick_word());
            if ($urandom_range(0, 4) == 0)
              add_op(op_t'($urandom_range(0, 9)), pick_reg(), pick_reg(), 16'($urandom()));
          end
          extra = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 3) : 0;
          for (k = 0; k < depth + extra; k++) begin
            add_op(OP_POP, pick_reg(), pick_reg(), 16'($urandom()));
          end
        end
        6: begin
          add_op(OP_SETPC, pick_reg(), pick_reg(), pick_word());
          count = $urandom_range(1, 6);
          for (k = 0; k < count; k++) begin
            add_op($urandom_range(0, 1) ? OP_PC1 : OP_PC2, pick_reg(), pick_reg(),
                   16'($urandom()));
          end
        end
        default: begin
          count = $urandom_range(2, 10);
          for (k = 0; k < count; k++) begin
            add_op(op_t'($urandom_range(0, 15)), 4'($urandom()), 4'($urandom()),
                   16'($urandom()));
          end
        end
      endcase
    end
    total_ops = op_program.size();

    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // Wait for a response to every command, then run the drain so that
    // a response the block should not have produced still gets caught.
    while (rsp_count < total_ops) @(negedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    @(negedge clk);
    if (op_outcomes.size() != 0)
      report_mismatch("outcomes left without response", 16'(op_outcomes.size()), 16'd0);

    if (error_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
